FILE: hw/rtl/tlcd_pkg.sv
// ----------------------------------------------------------------------------
// tlcd_pkg
// Shared types, constants and the 5x7 font table for the text-to-LCD
// serial writer.
// ----------------------------------------------------------------------------
package tlcd_pkg;

  localparam logic [7:0] PAGE_ROWS    = 8'd8;
  localparam logic [7:0] TEXT_COLUMNS = 8'd21;
  localparam logic [7:0] CELL_WIDTH   = 8'd6;
  localparam int         GLYPH_WIDTH  = 5;

  localparam logic [7:0] FIRST_CODE = 8'h20;
  localparam logic [7:0] END_CODE   = 8'h7e;
  localparam logic [7:0] CMD_PAGE   = 8'hb0;
  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [3:0] NIB_ZERO   = 4'h0;

  // Byte slots of one character: three address commands, then the glyph.
  localparam logic [2:0] SLOT_PAGE   = 3'd0;
  localparam logic [2:0] SLOT_COL_HI = 3'd1;
  localparam logic [2:0] SLOT_COL_LO = 3'd2;
  localparam logic [2:0] SLOT_GLYPH0 = 3'd3;
  localparam logic [2:0] SLOT_LAST   = 3'(3 + GLYPH_WIDTH - 1);
  localparam logic [2:0] BIT_LAST    = 3'd7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_SHIFT
  } state_t;

  typedef struct packed {
    logic load;   // take the request and its position
    logic start;  // pick the first byte and load the shifter
    logic shift;  // move one bit into the output register
  } cmd_t;

  typedef struct packed {
    logic printable;  // incoming code lies in 0x20..0x7d
    logic can_emit;   // output register is free this cycle
    logic bit_last;   // shifter holds the eighth bit of a byte
    logic byte_last;  // current byte is the final glyph column
  } status_t;

  // Five glyph columns, column 0 in the top byte.
  function automatic logic [39:0] font_glyph(input logic [6:0] g);
    logic [39:0] v;
    case (g)
      7'd0:  v = 40'h0000000000; 7'd1:  v = 40'h00004f0000;
      7'd2:  v = 40'h0007000700; 7'd3:  v = 40'h147f147f14;
      7'd4:  v = 40'h242a7f2a12; 7'd5:  v = 40'h2313086462;
      7'd6:  v = 40'h3649552250; 7'd7:  v = 40'h0005070000;
      7'd8:  v = 40'h001c224100; 7'd9:  v = 40'h0041221c00;
      7'd10: v = 40'h14083e0814; 7'd11: v = 40'h08083e0808;
      7'd12: v = 40'h0050300000; 7'd13: v = 40'h0808080808;
      7'd14: v = 40'h0060600000; 7'd15: v = 40'h2010080402;
      7'd16: v = 40'h3e5149453e; 7'd17: v = 40'h00427f4000;
      7'd18: v = 40'h4261514946; 7'd19: v = 40'h2141454b31;
      7'd20: v = 40'h1814127f10; 7'd21: v = 40'h2745454539;
      7'd22: v = 40'h3c4a494930; 7'd23: v = 40'h0171090503;
      7'd24: v = 40'h3649494936; 7'd25: v = 40'h064949291e;
      7'd26: v = 40'h0036360000; 7'd27: v = 40'h0056360000;
      7'd28: v = 40'h0814224100; 7'd29: v = 40'h1414141414;
      7'd30: v = 40'h0041221408; 7'd31: v = 40'h0201510906;
      7'd32: v = 40'h324979413e; 7'd33: v = 40'h7e1111117e;
      7'd34: v = 40'h7f49494936; 7'd35: v = 40'h3e41414122;
      7'd36: v = 40'h7f4141221c; 7'd37: v = 40'h7f49494941;
      7'd38: v = 40'h7f09090901; 7'd39: v = 40'h3e4149497a;
      7'd40: v = 40'h7f0808087f; 7'd41: v = 40'h00417f4100;
      7'd42: v = 40'h2040413f01; 7'd43: v = 40'h7f08142241;
      7'd44: v = 40'h7f40404040; 7'd45: v = 40'h7f020c027f;
      7'd46: v = 40'h7f0408107f; 7'd47: v = 40'h3e4141413e;
      7'd48: v = 40'h7f09090906; 7'd49: v = 40'h3e4151215e;
      7'd50: v = 40'h7f09192946; 7'd51: v = 40'h4649494931;
      7'd52: v = 40'h01017f0101; 7'd53: v = 40'h3f4040403f;
      7'd54: v = 40'h1f2040201f; 7'd55: v = 40'h3f4038403f;
      7'd56: v = 40'h6314081463; 7'd57: v = 40'h0708700807;
      7'd58: v = 40'h6151494543; 7'd59: v = 40'h007f414100;
      7'd60: v = 40'h0204081020; 7'd61: v = 40'h0041417f00;
      7'd62: v = 40'h0402010204; 7'd63: v = 40'h4040404040;
      7'd64: v = 40'h0102040000; 7'd65: v = 40'h2054545478;
      7'd66: v = 40'h7f48484830; 7'd67: v = 40'h3844444444;
      7'd68: v = 40'h304848487f; 7'd69: v = 40'h3854545458;
      7'd70: v = 40'h00087e0902; 7'd71: v = 40'h485454543c;
      7'd72: v = 40'h7f08080870; 7'd73: v = 40'h00007a0000;
      7'd74: v = 40'h2040403d00; 7'd75: v = 40'h7f20284400;
      7'd76: v = 40'h00417f4000; 7'd77: v = 40'h7c0438047c;
      7'd78: v = 40'h7c08040478; 7'd79: v = 40'h3844444438;
      7'd80: v = 40'h7c14141408; 7'd81: v = 40'h081414147c;
      7'd82: v = 40'h7c08040408; 7'd83: v = 40'h4854545424;
      7'd84: v = 40'h04043f4424; 7'd85: v = 40'h3c4040403c;
      7'd86: v = 40'h1c2040201c; 7'd87: v = 40'h3c4030403c;
      7'd88: v = 40'h4428102844; 7'd89: v = 40'h0448300804;
      7'd90: v = 40'h4464544c44; 7'd91: v = 40'h0836414100;
      7'd92: v = 40'h0000770000; 7'd93: v = 40'h0041413608;
      7'd94: v = 40'h0402020201;
      default: v = 40'h0000000000;
    endcase
    return v;
  endfunction

endpackage

FILE: hw/rtl/tlcd_ctrl.sv
// ----------------------------------------------------------------------------
// tlcd_ctrl
// Sequencer: takes a request, starts the byte run and paces the bit shifts.
// ----------------------------------------------------------------------------
module tlcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  tlcd_pkg::status_t status,
  output tlcd_pkg::cmd_t    cmd
);

  tlcd_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlcd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      tlcd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          // A code outside the printable range gives nothing, so the next request is free.
          if (status.printable) begin
            state_nxt = tlcd_pkg::ST_START;
          end
        end
      end
      tlcd_pkg::ST_START: begin
        cmd.start = 1'b1;
        state_nxt = tlcd_pkg::ST_SHIFT;
      end
      tlcd_pkg::ST_SHIFT: begin
        if (status.can_emit) begin
          cmd.shift = 1'b1;
          if (status.bit_last && status.byte_last) begin
            state_nxt = tlcd_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tlcd_pkg::ST_IDLE;
      end
    endcase
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.start, cmd.shift}))
    else $error("more than one datapath command at once");

  a_start_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load && status.printable |=> cmd.start)
    else $error("printable request not started");

  a_shift_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> status.can_emit)
    else $error("bit shifted while output register is full");

endmodule

FILE: hw/rtl/tlcd_datapath.sv
// ----------------------------------------------------------------------------
// tlcd_datapath
// Position registers, byte builder, bit shifter and output register.
// ----------------------------------------------------------------------------
module tlcd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [23:0]       in_tdata,
  input  logic [0:0]        in_tuser,
  input  tlcd_pkg::cmd_t    cmd,
  output tlcd_pkg::status_t status,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,
  output logic [1:0]        out_tuser,
  output logic              out_tlast
);

  logic [7:0] row_r, col_r, code_r;
  logic [7:0] sh_r;
  logic [2:0] bit_cnt_r;
  logic [2:0] slot_r;
  logic       out_valid_r, sda_r, rs_r, byte_done_r, last_r;

  logic [7:0] in_code;
  logic [7:0] col_inc;
  logic [7:0] addr;
  logic       on_screen;
  logic [2:0] first_slot;
  logic [2:0] slot_next;
  logic [7:0] first_byte, next_byte;

  assign in_code = in_tdata[7:0];

  // Pixel column of the cell, kept at 8 bits as the panel expects.
  assign col_inc   = col_r + 8'd1;
  assign addr      = 8'(col_inc * tlcd_pkg::CELL_WIDTH);
  assign on_screen = (row_r < tlcd_pkg::PAGE_ROWS) && (col_r < tlcd_pkg::TEXT_COLUMNS);
  assign first_slot = on_screen ? tlcd_pkg::SLOT_PAGE : tlcd_pkg::SLOT_GLYPH0;
  assign slot_next  = slot_r + 3'd1;

  function automatic logic [7:0] slot_byte(input logic [2:0] slot, input logic [7:0] row,
                                           input logic [7:0] a, input logic [7:0] code);
    logic [39:0] glyph;
    logic [2:0]  k;
    glyph = tlcd_pkg::font_glyph(7'(code - tlcd_pkg::FIRST_CODE));
    k     = slot - tlcd_pkg::SLOT_GLYPH0;
    case (slot)
      tlcd_pkg::SLOT_PAGE:   slot_byte = tlcd_pkg::CMD_PAGE | {4'h0, row[3:0]};
      tlcd_pkg::SLOT_COL_HI: slot_byte = tlcd_pkg::CMD_COL_HI | {4'h0, a[7:4]};
      tlcd_pkg::SLOT_COL_LO: slot_byte = {tlcd_pkg::NIB_ZERO, a[3:0]};
      default:               slot_byte = glyph[(3'd4 - k) * 8 +: 8];
    endcase
  endfunction

  assign first_byte = slot_byte(first_slot, row_r, addr, code_r);
  assign next_byte  = slot_byte(slot_next, row_r, addr, code_r);

  assign status.printable = (in_code >= tlcd_pkg::FIRST_CODE) &&
                            (in_code < tlcd_pkg::END_CODE);
  assign status.can_emit  = !out_valid_r || out_tready;
  assign status.bit_last  = (bit_cnt_r == tlcd_pkg::BIT_LAST);
  assign status.byte_last = (slot_r == tlcd_pkg::SLOT_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.load && in_tuser[0]) begin
      row_r <= in_tdata[15:8];
      col_r <= in_tdata[23:16];
    end else if (cmd.shift && status.bit_last && status.byte_last) begin
      col_r <= col_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.shift) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      code_r <= in_code;
    end
    if (cmd.start) begin
      slot_r    <= first_slot;
      sh_r      <= first_byte;
      bit_cnt_r <= '0;
    end else if (cmd.shift) begin
      bit_cnt_r <= bit_cnt_r + 3'd1;
      // The next byte is loaded on the eighth bit, so bytes run back to back.
      if (status.bit_last) begin
        slot_r <= slot_next;
        sh_r   <= next_byte;
      end else begin
        sh_r <= {sh_r[6:0], 1'b0};
      end
    end
    if (cmd.shift) begin
      sda_r       <= sh_r[7];
      rs_r        <= (slot_r >= tlcd_pkg::SLOT_GLYPH0);
      byte_done_r <= status.bit_last;
      last_r      <= status.bit_last && status.byte_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, sda_r};
  assign out_tuser  = {byte_done_r, rs_r};
  assign out_tlast  = last_r;

  a_last_ends_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser[1] && out_tuser[0])
    else $error("final bit is not the end of a glyph byte");

  a_start_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> bit_cnt_r == 3'd0 &&
                  (slot_r == tlcd_pkg::SLOT_PAGE || slot_r == tlcd_pkg::SLOT_GLYPH0))
    else $error("byte run started at a wrong slot");

  a_col_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift && status.bit_last && status.byte_last |=> col_r == $past(col_inc))
    else $error("column did not advance after a character");

  a_tail_emitted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift && status.bit_last && status.byte_last |=> out_tvalid && out_tlast)
    else $error("final bit not presented");

endmodule

FILE: hw/rtl/text_to_lcd_serial_writer.sv
// ----------------------------------------------------------------------------
// text_to_lcd_serial_writer
// Turns characters into the serial bit stream of a paged LCD: address
// commands (on screen only) followed by five 5x7 font columns, one bit per result.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      slave      tdata {start_column, row, char_code}, tuser first_of_string
//  out_     master     tdata sda_bit, tuser {byte_done, register_select}, tlast
//
//  A drawn character on screen goes through accept, shifter load and 64
//  bits; off screen the address commands are skipped (40 bits). A code
//  outside 0x20..0x7d is taken with no output. The bit shifter sets the pace
//  at one bit a cycle unless backpressure on out_tready holds it. Reset clears
//  the row and column to zero; no new request is taken until a character's last bit is sent.
// ----------------------------------------------------------------------------
module text_to_lcd_serial_writer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], row[15:8], start_column[23:16]
  input  logic [0:0]  in_tuser,   // first_of_string[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // sda_bit[0], zero fill above
  output logic [1:0]  out_tuser,  // register_select[0], byte_done[1]
  output logic        out_tlast
);

  tlcd_pkg::cmd_t    cmd;
  tlcd_pkg::status_t status;

  tlcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tlcd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
